>>> rtl/rcfp_pkg.sv
// Shared types, constants and helpers of the rolling-code frame pair decoder.
`default_nettype none
package rcfp_pkg;

	localparam int WORD_W  = 62;
	localparam int FIXED_W = 20;
	localparam int CNT_W   = 28;
	localparam int SER_W   = 32;
	localparam int BTN_W   = 4;
	localparam int GRP_W   = 10;
	localparam int ROLL_W  = 29;
	localparam int IN_W    = 64;
	localparam int OUT_W   = 128;

	localparam logic [WORD_W-1:0] HDR_MASK  = 62'h3FFF_3C00_0000_0000;
	localparam logic [WORD_W-1:0] HDR_VALUE = 62'h0000_3C00_0000_0000;
	localparam logic [1:0]        TYPE_ONE  = 2'b00;
	localparam logic [1:0]        TYPE_TWO  = 2'b01;
	localparam logic [9:0]        WORD10    = 10'h3FF;
	localparam logic [1:0]        TRIT_BAD  = 2'b11;

	// invert codes
	localparam logic [3:0] INV_Q01   = 4'h0;
	localparam logic [3:0] INV_Q1    = 4'h1;
	localparam logic [3:0] INV_Q2    = 4'h2;
	localparam logic [3:0] INV_ALL   = 4'h4;
	localparam logic [3:0] INV_Q02_A = 4'h5;
	localparam logic [3:0] INV_Q12   = 4'h6;
	localparam logic [3:0] INV_Q0    = 4'h8;
	localparam logic [3:0] INV_NONE  = 4'h9;
	localparam logic [3:0] INV_Q02_B = 4'hA;

	// order codes
	localparam logic [3:0] ORD_CBA_A = 4'h6;
	localparam logic [3:0] ORD_CBA_B = 4'h9;
	localparam logic [3:0] ORD_CAB_A = 4'h8;
	localparam logic [3:0] ORD_CAB_B = 4'h4;
	localparam logic [3:0] ORD_BCA   = 4'h1;
	localparam logic [3:0] ORD_ACB   = 4'h0;
	localparam logic [3:0] ORD_BAC   = 4'h5;

	typedef struct packed {
		logic               ok;
		logic [FIXED_W-1:0] fixed;
		logic [8:0][1:0]    trits;
	} half_t;

	typedef struct packed {
		logic             in_range;
		logic [CNT_W-1:0] counter;
	} cnt_t;

	// value of six base-3 digits, most significant digit in the top bits
	function automatic logic [GRP_W-1:0] trits6_value(input logic [11:0] t);
		logic [GRP_W-1:0] v;
		v = GRP_W'(t[11:10]) * GRP_W'(243) + GRP_W'(t[9:8]) * GRP_W'(81)
			+ GRP_W'(t[7:6]) * GRP_W'(27) + GRP_W'(t[5:4]) * GRP_W'(9)
			+ GRP_W'(t[3:2]) * GRP_W'(3) + GRP_W'(t[1:0]);
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/rolling_code_frame_pair_decoder.sv
// Top level of the rolling-code frame pair decoder.
//
//   channel  | dir | tdata fields, low bit up
//   ---------+-----+-----------------------------------------------------------
//   s_axis   | in  | received_word[61:0], clear_first[62], zero[63]
//   m_axis   | out | decode_ok[0], serial_number[32:1], button[36:33],
//            |     | rolling_counter[64:37], raw_key[126:65], zero[127]
//
// One item is accepted per cycle unless a stalled output holds the pipeline.
// A result passes in order: input register, unscramble and trit grouping, counter.
// Items with no result leave an empty stage in the pipeline.
// Reset clears the stored first frame and empties every stage.
// A stalled output holds its stages; stages with no item still fill.
`default_nettype none
module rolling_code_frame_pair_decoder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output      logic                      s_tready,
	input  wire logic [rcfp_pkg::IN_W-1:0] s_tdata,  // received_word, clear_first
	output      logic                      m_tvalid,
	input  wire logic                      m_tready,
	output      logic [rcfp_pkg::OUT_W-1:0] m_tdata  // decode_ok, serial_number,
	                                                 // button, rolling_counter, raw_key
);

	logic [rcfp_pkg::WORD_W-1:0] in_word;
	logic                        in_clear;
	logic [rcfp_pkg::WORD_W-1:0] first_q;
	logic [rcfp_pkg::WORD_W-1:0] eff_first;
	logic                        hdr_ok;
	logic                        is_one;
	logic                        gives_result;
	logic                        accept;
	logic                        adv1, adv2;

	logic                        v_s1;
	logic [rcfp_pkg::WORD_W-1:0] w_s1;
	logic [rcfp_pkg::WORD_W-1:0] first_s1;

	rcfp_pkg::half_t             half1, half2;

	logic                         v_s2;
	logic                         ok_s2;
	logic [rcfp_pkg::FIXED_W-1:0] f1_s2, f2_s2;
	logic [rcfp_pkg::GRP_W-1:0]   g_hi_s2, g_mid_s2, g_lo_s2;
	logic [rcfp_pkg::WORD_W-1:0]  raw_s2;

	rcfp_pkg::cnt_t               cnt;
	logic                         ok_all;

	logic                         v_s3;
	logic                         ok_s3;
	logic [rcfp_pkg::SER_W-1:0]   serial_s3;
	logic [rcfp_pkg::BTN_W-1:0]   button_s3;
	logic [rcfp_pkg::CNT_W-1:0]   counter_s3;
	logic [rcfp_pkg::WORD_W-1:0]  raw_s3;

	assign in_word  = s_tdata[rcfp_pkg::WORD_W-1:0];
	assign in_clear = s_tdata[rcfp_pkg::WORD_W];

	assign adv2     = ~v_s3 | m_tready;
	assign adv1     = ~v_s2 | adv2;
	assign s_tready = adv1;
	assign accept   = s_tvalid & s_tready;

	assign eff_first    = in_clear ? '0 : first_q;
	assign hdr_ok       = (in_word & rcfp_pkg::HDR_MASK) == rcfp_pkg::HDR_VALUE;
	assign is_one       = hdr_ok & (in_word[41:40] == rcfp_pkg::TYPE_ONE);
	assign gives_result = hdr_ok & (in_word[41:40] == rcfp_pkg::TYPE_TWO)
		& (eff_first != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			if (accept) begin
				if (is_one) begin
					first_q <= in_word;
				end else if (in_clear) begin
					first_q <= '0;
				end
			end
			if (adv1) begin
				v_s1 <= accept & gives_result;
				v_s2 <= v_s1;
			end
			if (adv2) begin
				v_s3 <= v_s2;
			end
		end
	end

	rcfp_unscramble u_half1 (
		.word (first_s1),
		.half (half1)
	);

	rcfp_unscramble u_half2 (
		.word (w_s1),
		.half (half2)
	);

	rcfp_counter u_counter (
		.grp_hi  (g_hi_s2),
		.grp_mid (g_mid_s2),
		.grp_lo  (g_lo_s2),
		.cnt     (cnt)
	);

	assign ok_all = ok_s2 & cnt.in_range;

	always_ff @(posedge clk) begin
		if (accept & gives_result & adv1) begin
			w_s1     <= in_word;
			first_s1 <= eff_first;
		end
		if (v_s1 & adv1) begin
			ok_s2    <= half1.ok & half2.ok;
			f1_s2    <= half1.fixed;
			f2_s2    <= half2.fixed;
			raw_s2   <= w_s1;
			g_hi_s2  <= rcfp_pkg::trits6_value({half2.trits[8], half1.trits[8],
				half2.trits[4], half2.trits[5], half2.trits[6], half2.trits[7]});
			g_mid_s2 <= rcfp_pkg::trits6_value({half1.trits[4], half1.trits[5],
				half1.trits[6], half1.trits[7], half2.trits[0], half2.trits[1]});
			g_lo_s2  <= rcfp_pkg::trits6_value({half2.trits[2], half2.trits[3],
				half1.trits[0], half1.trits[1], half1.trits[2], half1.trits[3]});
		end
		if (v_s2 & adv2) begin
			ok_s3      <= ok_all;
			serial_s3  <= ok_all ? {f1_s2[11:0], f2_s2} : '0;
			button_s3  <= ok_all ? f1_s2[15:12] : '0;
			counter_s3 <= ok_all ? cnt.counter : '0;
			raw_s3     <= raw_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {1'b0, raw_s3, counter_s3, button_s3, serial_s3, ok_s3};

endmodule
`default_nettype wire

>>> rtl/rcfp_unscramble.sv
// Unscrambler for one half frame: de-interleave, invert, permute, extract trits.
`default_nettype none
module rcfp_unscramble (
	input  wire logic [rcfp_pkg::WORD_W-1:0] word,
	output rcfp_pkg::half_t                  half
);

	logic [3:0] ord;
	logic [3:0] inv;
	logic [9:0] qa, qb, qc;
	logic [9:0] ia, ib, ic;
	logic [9:0] pa, pb, pc;
	logic       inv_ok;
	logic [7:0] head;
	logic       bad_trit;

	assign ord  = word[37:34];
	assign inv  = word[33:30];
	assign head = {ord, inv};

	always_comb begin
		for (int j = 0; j < 10; j++) begin
			qa[9-j] = word[29-3*j];
			qb[9-j] = word[28-3*j];
			qc[9-j] = word[27-3*j];
		end
	end

	always_comb begin
		ia     = qa;
		ib     = qb;
		ic     = qc;
		inv_ok = 1'b1;
		unique case (inv)
			rcfp_pkg::INV_Q01: begin
				ia = qa ^ rcfp_pkg::WORD10;
				ib = qb ^ rcfp_pkg::WORD10;
			end
			rcfp_pkg::INV_Q1:  ib = qb ^ rcfp_pkg::WORD10;
			rcfp_pkg::INV_Q2:  ic = qc ^ rcfp_pkg::WORD10;
			rcfp_pkg::INV_ALL: begin
				ia = qa ^ rcfp_pkg::WORD10;
				ib = qb ^ rcfp_pkg::WORD10;
				ic = qc ^ rcfp_pkg::WORD10;
			end
			rcfp_pkg::INV_Q02_A, rcfp_pkg::INV_Q02_B: begin
				ia = qa ^ rcfp_pkg::WORD10;
				ic = qc ^ rcfp_pkg::WORD10;
			end
			rcfp_pkg::INV_Q12: begin
				ib = qb ^ rcfp_pkg::WORD10;
				ic = qc ^ rcfp_pkg::WORD10;
			end
			rcfp_pkg::INV_Q0:   ia = qa ^ rcfp_pkg::WORD10;
			rcfp_pkg::INV_NONE: inv_ok = 1'b1;
			default:            inv_ok = 1'b0;
		endcase
	end

	always_comb begin
		pa = ia;
		pb = ib;
		pc = ic;
		unique case (ord)
			rcfp_pkg::ORD_CBA_A, rcfp_pkg::ORD_CBA_B: begin
				pc = ia;
				pa = ic;
			end
			rcfp_pkg::ORD_CAB_A, rcfp_pkg::ORD_CAB_B: begin
				pb = ia;
				pc = ib;
				pa = ic;
			end
			rcfp_pkg::ORD_BCA: begin
				pc = ia;
				pa = ib;
				pb = ic;
			end
			rcfp_pkg::ORD_ACB: begin
				pc = ib;
				pb = ic;
			end
			rcfp_pkg::ORD_BAC: begin
				pb = ia;
				pa = ib;
			end
			default: pa = ia;
		endcase
	end

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			half.trits[n] = head[7-2*n -: 2];
		end
		for (int n = 0; n < 5; n++) begin
			half.trits[4+n] = pc[9-2*n -: 2];
		end
		bad_trit = 1'b0;
		for (int n = 0; n < 9; n++) begin
			bad_trit = bad_trit | (half.trits[n] == rcfp_pkg::TRIT_BAD);
		end
		half.ok    = inv_ok & ~bad_trit;
		half.fixed = {pa, pb};
	end

endmodule
`default_nettype wire

>>> rtl/rcfp_counter.sv
// Ternary group combiner, range check and bit reversal of the rolling counter.
`default_nettype none
module rcfp_counter (
	input  wire logic [rcfp_pkg::GRP_W-1:0] grp_hi,
	input  wire logic [rcfp_pkg::GRP_W-1:0] grp_mid,
	input  wire logic [rcfp_pkg::GRP_W-1:0] grp_lo,
	output rcfp_pkg::cnt_t                  cnt
);

	logic [rcfp_pkg::ROLL_W-1:0] roll;

	assign roll = rcfp_pkg::ROLL_W'(grp_hi) * rcfp_pkg::ROLL_W'(531441)
		+ rcfp_pkg::ROLL_W'(grp_mid) * rcfp_pkg::ROLL_W'(729)
		+ rcfp_pkg::ROLL_W'(grp_lo);

	always_comb begin
		cnt.in_range = ~roll[rcfp_pkg::ROLL_W-1];
		for (int i = 0; i < rcfp_pkg::CNT_W; i++) begin
			cnt.counter[i] = roll[rcfp_pkg::CNT_W-1-i];
		end
	end

endmodule
`default_nettype wire

>>> rtl/rcfp_checker.sv
// Port-level assertions of the rolling-code frame pair decoder, with bind.
`default_nettype none
module rcfp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [rcfp_pkg::OUT_W-1:0] m_tdata
);

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid && !m_tready)
		else $error("input held back while the output is free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output item changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == 64'd0)
		else $error("failed decode carries nonzero fields");

	a_raw_type2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[106:105] == rcfp_pkg::TYPE_TWO
			&& m_tdata[110:107] == 4'hF && m_tdata[126:113] == 14'd0)
		else $error("raw key is not a valid second frame");

endmodule

bind rolling_code_frame_pair_decoder rcfp_checker u_rcfp_checker (.*);
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the rolling-code frame pair decoder: directed pairs, then random streams.
module tb_top;
	import rcfp_pkg::*;

	localparam int          PIPE_LATENCY = 3;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          LIMIT_CYCLES = 400_000;
	localparam int          ITEMS        = 2000;
	localparam logic [1:0]  TYPE_THREE   = 2'b11;
	localparam logic [3:0]  HDR_MARK     = 4'hF;
	localparam logic [3:0]  ORD_KEEP     = 4'h2;
	localparam logic [3:0]  ORD_BAD      = 4'hC;
	localparam logic [3:0]  INV_BAD      = 4'h3;
	localparam logic [31:0] COUNTER_SPAN = 32'h1000_0000;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic               ok;
		logic [FIXED_W-1:0] fixed;
		logic [8:0][1:0]    trits;
	} half_view_t;

	typedef struct packed {
		logic              decode_ok;
		logic [SER_W-1:0]  serial;
		logic [BTN_W-1:0]  button;
		logic [CNT_W-1:0]  counter;
		logic [WORD_W-1:0] raw_key;
	} pair_result_t;

	function automatic half_view_t unscramble(input logic [WORD_W-1:0] w);
		half_view_t h;
		logic [3:0] ord, inv;
		logic [9:0] q0, q1, q2, a, b, c;
		logic [7:0] head;
		h = '0;
		ord = w[37:34];
		inv = w[33:30];
		for (int k = 0; k < 10; k++) begin
			q0[9-k] = w[29-3*k];
			q1[9-k] = w[28-3*k];
			q2[9-k] = w[27-3*k];
		end
		case (inv)
			INV_Q01: begin
				q0 ^= WORD10;
				q1 ^= WORD10;
			end
			INV_Q1: q1 ^= WORD10;
			INV_Q2: q2 ^= WORD10;
			INV_ALL: begin
				q0 ^= WORD10;
				q1 ^= WORD10;
				q2 ^= WORD10;
			end
			INV_Q02_A, INV_Q02_B: begin
				q0 ^= WORD10;
				q2 ^= WORD10;
			end
			INV_Q12: begin
				q1 ^= WORD10;
				q2 ^= WORD10;
			end
			INV_Q0: q0 ^= WORD10;
			INV_NONE: ;
			default: return h;
		endcase
		a = q0;
		b = q1;
		c = q2;
		case (ord)
			ORD_CBA_A, ORD_CBA_B: begin
				q2 = a;
				q0 = c;
			end
			ORD_CAB_A, ORD_CAB_B: begin
				q1 = a;
				q2 = b;
				q0 = c;
			end
			ORD_BCA: begin
				q2 = a;
				q0 = b;
				q1 = c;
			end
			ORD_ACB: begin
				q2 = b;
				q1 = c;
			end
			ORD_BAC: begin
				q1 = a;
				q0 = b;
			end
			default: ;
		endcase
		head = {ord, inv};
		for (int k = 0; k < 4; k++)
			h.trits[k] = head[7-2*k -: 2];
		for (int k = 0; k < 5; k++)
			h.trits[4+k] = q2[9-2*k -: 2];
		for (int k = 0; k < 9; k++)
			if (h.trits[k] == TRIT_BAD)
				return h;
		h.fixed = {q0, q1};
		h.ok = 1'b1;
		return h;
	endfunction

	function automatic pair_result_t predict_pair(input logic [WORD_W-1:0] first,
			input logic [WORD_W-1:0] second);
		pair_result_t r;
		half_view_t h1, h2;
		logic [31:0] roll;
		r = '0;
		r.raw_key = second;
		h1 = unscramble(first);
		h2 = unscramble(second);
		if (!h1.ok || !h2.ok)
			return r;
		roll = 32'(h2.trits[8]);
		roll = roll * 3 + 32'(h1.trits[8]);
		for (int k = 4; k < 8; k++)
			roll = roll * 3 + 32'(h2.trits[k]);
		for (int k = 4; k < 8; k++)
			roll = roll * 3 + 32'(h1.trits[k]);
		for (int k = 0; k < 4; k++)
			roll = roll * 3 + 32'(h2.trits[k]);
		for (int k = 0; k < 4; k++)
			roll = roll * 3 + 32'(h1.trits[k]);
		if (roll >= COUNTER_SPAN)
			return r;
		for (int k = 0; k < CNT_W; k++)
			r.counter[CNT_W-1-k] = roll[k];
		r.decode_ok = 1'b1;
		r.serial = {h1.fixed[11:0], h2.fixed};
		r.button = h1.fixed[15:12];
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] make_frame(input logic [1:0] ftype,
			input logic [3:0] ord, input logic [3:0] inv, input logic [29:0] payload,
			input logic [3:0] spare);
		return {14'd0, spare[3:2], HDR_MARK, ftype, spare[1:0], ord, inv, payload};
	endfunction

	function automatic logic [WORD_W-1:0] coded_frame(input logic [1:0] ftype,
			input logic [3:0] ord, input logic [3:0] inv, input bit want_ok);
		logic [WORD_W-1:0] w;
		half_view_t h;
		do begin
			w = make_frame(ftype, ord, inv, 30'($urandom), 4'($urandom));
			h = unscramble(w);
		end while (h.ok != want_ok);
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] random_frame(input logic [1:0] ftype,
			input bit want_ok);
		logic [WORD_W-1:0] w;
		half_view_t h;
		do begin
			w = make_frame(ftype, 4'($urandom), 4'($urandom), 30'($urandom), 4'($urandom));
			h = unscramble(w);
		end while (h.ok != want_ok);
		return w;
	endfunction

	class frame_pair_scoreboard;
		logic [WORD_W-1:0] stored_first;
		pair_result_t      awaited[$];
		int                mismatches;
		int                results_seen;
		int                good_results;

		function new();
			stored_first = '0;
			mismatches = 0;
			results_seen = 0;
			good_results = 0;
		endfunction

		function bit note_input(input logic [WORD_W-1:0] w, input logic clr);
			if (clr)
				stored_first = '0;
			if ((w & HDR_MASK) != HDR_VALUE)
				return 1'b0;
			if (w[41:40] == TYPE_ONE) begin
				stored_first = w;
				return 1'b1;
			end
			if (w[41:40] != TYPE_TWO || stored_first == '0)
				return 1'b0;
			awaited.push_back(predict_pair(stored_first, w));
			return 1'b1;
		endfunction

		function void check_result(input logic [OUT_W-1:0] t);
			pair_result_t got, want;
			got.decode_ok = t[0];
			got.serial = t[32:1];
			got.button = t[36:33];
			got.counter = t[64:37];
			got.raw_key = t[126:65];
			results_seen++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no frame pair pending: %h", t);
				return;
			end
			want = awaited.pop_front();
			if (want.decode_ok)
				good_results++;
			if (got.decode_ok !== want.decode_ok || got.serial !== want.serial
					|| got.button !== want.button || got.counter !== want.counter
					|| got.raw_key !== want.raw_key) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("mismatch (expected/actual): ok %b/%b serial %h/%h ",
						want.decode_ok, got.decode_ok, want.serial, got.serial);
					$display("button %h/%h counter %h/%h key %h/%h",
						want.button, got.button, want.counter, got.counter,
						want.raw_key, got.raw_key);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;

	frame_pair_scoreboard sb;
	int                   items_sent = 0;
	int                   items_acted = 0;
	int                   input_stalls = 0;
	int                   burst_left = 0;
	int                   cycle_count = 0;
	bit                   hold_off_req = 1'b0;

	rolling_code_frame_pair_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (arst_n && s_tvalid && !s_tready)
			input_stalls++;
	end

	task automatic send_item(input logic [WORD_W-1:0] w, input logic clr);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, clr, w};
		do @(posedge clk); while (s_tready !== 1'b1);
		items_sent++;
		items_acted += sb.note_input(w, clr);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(0, 60);
		end
	endtask

	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
		burst_left = $urandom_range(0, 60);
	endtask

	initial begin
		int       hold_left;
		int       rx_left;
		int       rx_tick;
		rx_mode_t rx_mode;
		m_tready <= 1'b0;
		hold_left = 0;
		rx_left = 0;
		rx_tick = 0;
		rx_mode = RX_OPEN;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_tick++;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(20, 300);
				end
				rx_left--;
				case (rx_mode)
					RX_OPEN: m_tready <= 1'b1;
					RX_COIN: m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= (rx_tick % 4 != 3);
				endcase
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles without completing", cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [WORD_W-1:0] t1, t2, w;
		logic [29:0]       zero_pay;
		pair_result_t      pr;
		int                pick;
		int                pos;
		bit                hold_done;
		bit                pause_done;
		sb = new();
		hold_done = 1'b0;
		pause_done = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		zero_pay = '0;
		for (int k = 0; k < 10; k++)
			zero_pay[28-3*k] = 1'b1;
		send_item(coded_frame(TYPE_TWO, ORD_ACB, INV_NONE, 1'b1), 1'b0);
		send_item('0, 1'b0);
		send_item('1, 1'b0);
		t1 = coded_frame(TYPE_ONE, ORD_BCA, INV_Q1, 1'b1);
		t1[42] = 1'b0;
		send_item(t1, 1'b0);
		send_item(make_frame(TYPE_ONE, ORD_ACB, INV_Q01, zero_pay, 4'h0), 1'b0);
		send_item(make_frame(TYPE_TWO, ORD_ACB, INV_Q01, zero_pay, 4'hF), 1'b0);
		send_item(random_frame(TYPE_TWO, 1'b1), 1'b0);
		send_item(random_frame(TYPE_THREE, 1'b1), 1'b0);
		send_item(coded_frame(TYPE_TWO, ORD_CAB_A, INV_BAD, 1'b0), 1'b0);
		send_item(coded_frame(TYPE_TWO, ORD_BAD, INV_Q2, 1'b0), 1'b0);
		send_item(coded_frame(TYPE_TWO, ORD_BAC, INV_ALL, 1'b0), 1'b0);
		send_item(coded_frame(TYPE_TWO, ORD_KEEP, INV_Q12, 1'b1), 1'b0);
		send_item(coded_frame(TYPE_TWO, ORD_CBA_B, INV_Q02_B, 1'b1), 1'b0);
		send_item(coded_frame(TYPE_ONE, ORD_CAB_B, INV_BAD, 1'b0), 1'b0);
		send_item(coded_frame(TYPE_TWO, ORD_CBA_A, INV_Q0, 1'b1), 1'b0);
		t1 = coded_frame(TYPE_ONE, ORD_BCA, INV_Q02_A, 1'b1);
		do begin
			t2 = random_frame(TYPE_TWO, 1'b1);
			pr = predict_pair(t1, t2);
		end while (pr.decode_ok);
		send_item(t1, 1'b0);
		send_item(t2, 1'b0);
		send_item(random_frame(TYPE_TWO, 1'b1), 1'b1);
		send_item(t1, 1'b0);
		w = 62'({$urandom, $urandom});
		w[61] = 1'b1;
		send_item(w, 1'b1);
		send_item(t2, 1'b0);
		send_item(random_frame(TYPE_ONE, 1'b1), 1'b1);
		send_item(random_frame(TYPE_TWO, 1'b1), 1'b0);
		drain_pipeline();

		items_acted = 0;
		while (items_acted < ITEMS) begin
			if (!hold_done && items_acted >= 600) begin
				hold_off_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && items_acted >= 1200) begin
				drain_pipeline();
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_item(random_frame(TYPE_ONE, 1'b1), $urandom_range(0, 3) == 0);
				repeat ($urandom_range(1, 3))
					send_item(random_frame(TYPE_TWO, $urandom_range(0, 9) != 0), 1'b0);
			end else if (pick < 70) begin
				send_item(random_frame(TYPE_TWO, 1'b1), $urandom_range(0, 4) == 0);
			end else if (pick < 80) begin
				send_item(make_frame(2'($urandom), 4'($urandom), 4'($urandom),
					30'($urandom), 4'($urandom)), $urandom_range(0, 7) == 0);
			end else if (pick < 85) begin
				send_item(62'({$urandom, $urandom}), $urandom_range(0, 7) == 0);
			end else if (pick < 90) begin
				w = random_frame(2'($urandom), 1'b1);
				pos = $urandom_range(0, 17);
				pos = (pos < 14) ? 48 + pos : 28 + pos;
				w[pos] = ~w[pos];
				send_item(w, 1'b0);
			end else begin
				send_item(random_frame(TYPE_ONE, 1'b0), 1'b0);
				send_item(random_frame(TYPE_TWO, 1'b1), 1'b0);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		$display("%0d frames offered, %0d stored or paired; %0d pairs checked, %0d decoded cleanly",
			items_sent, items_acted, sb.results_seen, sb.good_results);
		$display("input held back on %0d cycles across a %0d-cycle output stall and a full drain",
			input_stalls, HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
